[rtl/obb_pkg.sv]
// ----------------------------------------------------------------------------
// obb_pkg
// shared types, index tables and width helpers for the box overlap pipeline
// ----------------------------------------------------------------------------
package obb_pkg;

	localparam int NUM_AXES = 3;

	// cyclic successor tables for the axis product tests
	localparam int NEXT1 [NUM_AXES] = '{1, 2, 0};
	localparam int NEXT2 [NUM_AXES] = '{2, 0, 1};

	typedef struct packed {
		logic adv;
		logic vld;
	} obb_ctl_t;

	function automatic int max2(int a, int b);
		return (a > b) ? a : b;
	endfunction

endpackage

[rtl/obb_dot.sv]
// ----------------------------------------------------------------------------
// obb_dot
// stages 1-2: field unpack, center offset, axis dot products
// ----------------------------------------------------------------------------
module obb_dot #(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  obb_pkg::obb_ctl_t           ctl,
	output logic                        vld_s2,
	input  logic [47:0]                 box_a_center,
	input  logic [47:0]                 box_a_axis_u,
	input  logic [47:0]                 box_a_axis_v,
	input  logic [47:0]                 box_a_axis_w,
	input  logic [47:0]                 box_a_half_sizes,
	input  logic [47:0]                 box_b_center,
	input  logic [47:0]                 box_b_axis_u,
	input  logic [47:0]                 box_b_axis_v,
	input  logic [47:0]                 box_b_axis_w,
	input  logic [47:0]                 box_b_half_sizes,
	output logic signed [2*COORD_BITS+2:0] ad_s2 [3],
	output logic signed [2*COORD_BITS+2:0] bd_s2 [3],
	output logic signed [2*COORD_BITS+1:0] c_s2 [3][3],
	output logic [2*COORD_BITS+1:0]        ac_s2 [3][3],
	output logic [COORD_BITS-1:0]          ea_s2 [3],
	output logic [COORD_BITS-1:0]          eb_s2 [3]
);

	localparam int CB = COORD_BITS;
	localparam int WX = 3 * CB;
	localparam int WD = CB + 1;
	localparam int WC = 2 * CB + 2;
	localparam int WA = 2 * CB + 3;

	logic [WX-1:0] w_ca, w_cb, w_ea, w_eb;
	logic [WX-1:0] w_au [3];
	logic [WX-1:0] w_bu [3];

	assign w_ca = WX'(box_a_center);
	assign w_cb = WX'(box_b_center);
	assign w_ea = WX'(box_a_half_sizes);
	assign w_eb = WX'(box_b_half_sizes);
	assign w_au[0] = WX'(box_a_axis_u);
	assign w_au[1] = WX'(box_a_axis_v);
	assign w_au[2] = WX'(box_a_axis_w);
	assign w_bu[0] = WX'(box_b_axis_u);
	assign w_bu[1] = WX'(box_b_axis_v);
	assign w_bu[2] = WX'(box_b_axis_w);

	logic signed [CB-1:0]   au_c [3][3];
	logic signed [CB-1:0]   bu_c [3][3];
	logic signed [WD-1:0]   d_c [3];
	logic [CB-1:0]          ea_c [3];
	logic [CB-1:0]          eb_c [3];
	logic signed [2*CB-1:0] pc [3][3][3];
	logic signed [WC-1:0]   c_c [3][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k]  = WD'($signed(w_cb[k*CB +: CB])) - WD'($signed(w_ca[k*CB +: CB]));
			ea_c[k] = w_ea[k*CB +: CB];
			eb_c[k] = w_eb[k*CB +: CB];
			for (int i = 0; i < 3; i++) begin
				au_c[i][k] = $signed(w_au[i][k*CB +: CB]);
				bu_c[i][k] = $signed(w_bu[i][k*CB +: CB]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					pc[i][j][k] = au_c[i][k] * bu_c[j][k];
				end
				c_c[i][j] = WC'(pc[i][j][0]) + WC'(pc[i][j][1]) + WC'(pc[i][j][2]);
			end
		end
	end

	logic                 vld_s1;
	logic signed [CB-1:0] au_s1 [3][3];
	logic signed [CB-1:0] bu_s1 [3][3];
	logic signed [WD-1:0] d_s1 [3];
	logic [CB-1:0]        ea_s1 [3];
	logic [CB-1:0]        eb_s1 [3];
	logic signed [WC-1:0] c_s1 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			au_s1 <= au_c;
			bu_s1 <= bu_c;
			d_s1  <= d_c;
			ea_s1 <= ea_c;
			eb_s1 <= eb_c;
			c_s1  <= c_c;
		end
	end

	logic signed [CB+WD-1:0] pda [3][3];
	logic signed [CB+WD-1:0] pdb [3][3];
	logic signed [WA-1:0]    ad_c [3];
	logic signed [WA-1:0]    bd_c [3];
	logic [WC-1:0]           ac_c [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				pda[i][k] = au_s1[i][k] * d_s1[k];
				pdb[i][k] = bu_s1[i][k] * d_s1[k];
			end
			ad_c[i] = WA'(pda[i][0]) + WA'(pda[i][1]) + WA'(pda[i][2]);
			bd_c[i] = WA'(pdb[i][0]) + WA'(pdb[i][1]) + WA'(pdb[i][2]);
			for (int j = 0; j < 3; j++) begin
				ac_c[i][j] = c_s1[i][j][WC-1] ? WC'(-c_s1[i][j]) : WC'(c_s1[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			ad_s2 <= ad_c;
			bd_s2 <= bd_c;
			c_s2  <= c_s1;
			ac_s2 <= ac_c;
			ea_s2 <= ea_s1;
			eb_s2 <= eb_s1;
		end
	end

endmodule

[rtl/obb_prod.sv]
// ----------------------------------------------------------------------------
// obb_prod
// stage 3: offset magnitudes, extent products and split partial products of the axis tests
// ----------------------------------------------------------------------------
module obb_prod #(
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  obb_pkg::obb_ctl_t              ctl,
	output logic                           vld_s3,
	input  logic signed [2*COORD_BITS+2:0] ad_s2 [3],
	input  logic signed [2*COORD_BITS+2:0] bd_s2 [3],
	input  logic signed [2*COORD_BITS+1:0] c_s2 [3][3],
	input  logic [2*COORD_BITS+1:0]        ac_s2 [3][3],
	input  logic [COORD_BITS-1:0]          ea_s2 [3],
	input  logic [COORD_BITS-1:0]          eb_s2 [3],
	output logic [2*COORD_BITS+2:0]        absad_s3 [3],
	output logic [2*COORD_BITS+2:0]        absbd_s3 [3],
	output logic [COORD_BITS-1:0]          ea_s3 [3],
	output logic [COORD_BITS-1:0]          eb_s3 [3],
	output logic [3*COORD_BITS+1:0]        pa_s3 [3][3][3],
	output logic [3*COORD_BITS+1:0]        pb_s3 [3][3][3],
	output logic signed [3*COORD_BITS+4:0] ml0_s3 [3][3],
	output logic signed [3*COORD_BITS+4:0] ml1_s3 [3][3],
	output logic signed [3*COORD_BITS+3:0] mh0_s3 [3][3],
	output logic signed [3*COORD_BITS+3:0] mh1_s3 [3][3]
);

	localparam int CB = COORD_BITS;
	localparam int WC = 2 * CB + 2;
	localparam int WA = 2 * CB + 3;
	localparam int H  = WC / 2;
	localparam int WL = WA + H + 1;
	localparam int WH = WA + WC - H;

	logic [WA-1:0]        absad_c [3];
	logic [WA-1:0]        absbd_c [3];
	logic [3*CB+1:0]      pa_c [3][3][3];
	logic [3*CB+1:0]      pb_c [3][3][3];
	logic signed [WL-1:0] ml0_c [3][3];
	logic signed [WL-1:0] ml1_c [3][3];
	logic signed [WH-1:0] mh0_c [3][3];
	logic signed [WH-1:0] mh1_c [3][3];
	logic signed [H:0]    lo0, lo1;
	logic signed [WC-H-1:0] hi0, hi1;
	int i1, i2;

	always_comb begin
		lo0 = '0;
		lo1 = '0;
		hi0 = '0;
		hi1 = '0;
		i1  = 0;
		i2  = 0;
		for (int i = 0; i < 3; i++) begin
			absad_c[i] = ad_s2[i][WA-1] ? WA'(-ad_s2[i]) : WA'(ad_s2[i]);
			absbd_c[i] = bd_s2[i][WA-1] ? WA'(-bd_s2[i]) : WA'(bd_s2[i]);
			for (int b = 0; b < 3; b++) begin
				for (int j = 0; j < 3; j++) begin
					pa_c[i][b][j] = ea_s2[i] * ac_s2[b][j];
					pb_c[i][b][j] = eb_s2[i] * ac_s2[b][j];
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			i1 = obb_pkg::NEXT1[i];
			i2 = obb_pkg::NEXT2[i];
			for (int j = 0; j < 3; j++) begin
				lo0 = $signed({1'b0, c_s2[i1][j][H-1:0]});
				hi0 = $signed(c_s2[i1][j][WC-1:H]);
				lo1 = $signed({1'b0, c_s2[i2][j][H-1:0]});
				hi1 = $signed(c_s2[i2][j][WC-1:H]);
				ml0_c[i][j] = ad_s2[i2] * lo0;
				mh0_c[i][j] = ad_s2[i2] * hi0;
				ml1_c[i][j] = ad_s2[i1] * lo1;
				mh1_c[i][j] = ad_s2[i1] * hi1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s3 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			absad_s3 <= absad_c;
			absbd_s3 <= absbd_c;
			ea_s3    <= ea_s2;
			eb_s3    <= eb_s2;
			pa_s3    <= pa_c;
			pb_s3    <= pb_c;
			ml0_s3   <= ml0_c;
			ml1_s3   <= ml1_c;
			mh0_s3   <= mh0_c;
			mh1_s3   <= mh1_c;
		end
	end

endmodule

[rtl/obb_cmp.sv]
// ----------------------------------------------------------------------------
// obb_cmp
// stages 4-5: radius sums, face compares, axis product compares, final flag
// ----------------------------------------------------------------------------
module obb_cmp #(
	parameter int COORD_BITS     = 16,
	parameter int AXIS_FRAC_BITS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  obb_pkg::obb_ctl_t              ctl,
	output logic                           vld_s5,
	output logic                           overlap_s5,
	input  logic [2*COORD_BITS+2:0]        absad_s3 [3],
	input  logic [2*COORD_BITS+2:0]        absbd_s3 [3],
	input  logic [COORD_BITS-1:0]          ea_s3 [3],
	input  logic [COORD_BITS-1:0]          eb_s3 [3],
	input  logic [3*COORD_BITS+1:0]        pa_s3 [3][3][3],
	input  logic [3*COORD_BITS+1:0]        pb_s3 [3][3][3],
	input  logic signed [3*COORD_BITS+4:0] ml0_s3 [3][3],
	input  logic signed [3*COORD_BITS+4:0] ml1_s3 [3][3],
	input  logic signed [3*COORD_BITS+3:0] mh0_s3 [3][3],
	input  logic signed [3*COORD_BITS+3:0] mh1_s3 [3][3]
);

	localparam int CB = COORD_BITS;
	localparam int F  = AXIS_FRAC_BITS;
	localparam int WC = 2 * CB + 2;
	localparam int WA = 2 * CB + 3;
	localparam int H  = WC / 2;
	localparam int WP = 3 * CB + 2;
	localparam int WS = WP + 2;
	localparam int WF = obb_pkg::max2(obb_pkg::max2(WA + F, CB + 2 * F), WP) + 3;
	localparam int WR = obb_pkg::max2(WA + WC + 1, WS + F) + 1;

	logic [WF-1:0]        lhs_f, rhs_f;
	logic [5:0]           face_sep;
	logic signed [WR-1:0] m0, m1;
	logic signed [WR-1:0] diff_c [3][3];
	logic [WS-1:0]        rs_c [3][3];
	int i1, i2, j1, j2;

	always_comb begin
		lhs_f = '0;
		rhs_f = '0;
		m0    = '0;
		m1    = '0;
		i1    = 0;
		i2    = 0;
		j1    = 0;
		j2    = 0;
		for (int i = 0; i < 3; i++) begin
			lhs_f = WF'(absad_s3[i]) << F;
			rhs_f = (WF'(ea_s3[i]) << (2 * F)) + WF'(pb_s3[0][i][0])
				+ WF'(pb_s3[1][i][1]) + WF'(pb_s3[2][i][2]);
			face_sep[i] = lhs_f > rhs_f;
		end
		for (int j = 0; j < 3; j++) begin
			lhs_f = WF'(absbd_s3[j]) << F;
			rhs_f = (WF'(eb_s3[j]) << (2 * F)) + WF'(pa_s3[0][0][j])
				+ WF'(pa_s3[1][1][j]) + WF'(pa_s3[2][2][j]);
			face_sep[3 + j] = lhs_f > rhs_f;
		end
		for (int i = 0; i < 3; i++) begin
			i1 = obb_pkg::NEXT1[i];
			i2 = obb_pkg::NEXT2[i];
			for (int j = 0; j < 3; j++) begin
				j1 = obb_pkg::NEXT1[j];
				j2 = obb_pkg::NEXT2[j];
				m0 = (WR'(mh0_s3[i][j]) <<< H) + WR'(ml0_s3[i][j]);
				m1 = (WR'(mh1_s3[i][j]) <<< H) + WR'(ml1_s3[i][j]);
				diff_c[i][j] = m0 - m1;
				rs_c[i][j] = WS'(pa_s3[i1][i2][j]) + WS'(pa_s3[i2][i1][j])
					+ WS'(pb_s3[j1][i][j2]) + WS'(pb_s3[j2][i][j1]);
			end
		end
	end

	logic                 vld_s4;
	logic                 fsep_s4;
	logic signed [WR-1:0] diff_s4 [3][3];
	logic [WS-1:0]        rs_s4 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s4 <= ctl.vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			fsep_s4 <= |face_sep;
			diff_s4 <= diff_c;
			rs_s4   <= rs_c;
		end
	end

	logic [WR-1:0] mag;
	logic          sep;

	always_comb begin
		sep = fsep_s4;
		mag = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mag = diff_s4[i][j][WR-1] ? WR'(-diff_s4[i][j]) : WR'(diff_s4[i][j]);
				if (mag > (WR'(rs_s4[i][j]) << F)) begin
					sep = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			overlap_s5 <= ~sep;
		end
	end

endmodule

[rtl/obb_obb_overlap_test.sv]
// ----------------------------------------------------------------------------
// obb_obb_overlap_test
// oriented box pair overlap by 15-axis separating axis test, five stage pipe
// path: every input transfer is registered through stages s1 to s5 in turn
// throughput: one box pair per cycle; the whole pipe holds while a result waits
// stall: all five stage registers share one advance enable from the output side
// reset: arst_n clears every stage valid bit, payload registers are not reset
// ----------------------------------------------------------------------------
module obb_obb_overlap_test #(
	parameter int COORD_BITS     = 16,
	parameter int AXIS_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [47:0] box_a_center,
	input  logic [47:0] box_a_axis_u,
	input  logic [47:0] box_a_axis_v,
	input  logic [47:0] box_a_axis_w,
	input  logic [47:0] box_a_half_sizes,
	input  logic [47:0] box_b_center,
	input  logic [47:0] box_b_axis_u,
	input  logic [47:0] box_b_axis_v,
	input  logic [47:0] box_b_axis_w,
	input  logic [47:0] box_b_half_sizes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        overlap
);

	localparam int CB = COORD_BITS;

	logic adv;
	logic vld_s2, vld_s3, vld_s5;
	obb_pkg::obb_ctl_t ctl_dot, ctl_prod, ctl_cmp;

	assign adv      = ~vld_s5 | out_ready;
	assign in_ready = adv;
	assign ctl_dot  = '{adv: adv, vld: in_valid};
	assign ctl_prod = '{adv: adv, vld: vld_s2};
	assign ctl_cmp  = '{adv: adv, vld: vld_s3};

	logic signed [2*CB+2:0] ad_s2 [3];
	logic signed [2*CB+2:0] bd_s2 [3];
	logic signed [2*CB+1:0] c_s2 [3][3];
	logic [2*CB+1:0]        ac_s2 [3][3];
	logic [CB-1:0]          ea_s2 [3];
	logic [CB-1:0]          eb_s2 [3];

	obb_dot #(.COORD_BITS(CB)) u_dot (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl_dot),
		.vld_s2           (vld_s2),
		.box_a_center     (box_a_center),
		.box_a_axis_u     (box_a_axis_u),
		.box_a_axis_v     (box_a_axis_v),
		.box_a_axis_w     (box_a_axis_w),
		.box_a_half_sizes (box_a_half_sizes),
		.box_b_center     (box_b_center),
		.box_b_axis_u     (box_b_axis_u),
		.box_b_axis_v     (box_b_axis_v),
		.box_b_axis_w     (box_b_axis_w),
		.box_b_half_sizes (box_b_half_sizes),
		.ad_s2            (ad_s2),
		.bd_s2            (bd_s2),
		.c_s2             (c_s2),
		.ac_s2            (ac_s2),
		.ea_s2            (ea_s2),
		.eb_s2            (eb_s2)
	);

	logic [2*CB+2:0]        absad_s3 [3];
	logic [2*CB+2:0]        absbd_s3 [3];
	logic [CB-1:0]          ea_s3 [3];
	logic [CB-1:0]          eb_s3 [3];
	logic [3*CB+1:0]        pa_s3 [3][3][3];
	logic [3*CB+1:0]        pb_s3 [3][3][3];
	logic signed [3*CB+4:0] ml0_s3 [3][3];
	logic signed [3*CB+4:0] ml1_s3 [3][3];
	logic signed [3*CB+3:0] mh0_s3 [3][3];
	logic signed [3*CB+3:0] mh1_s3 [3][3];

	obb_prod #(.COORD_BITS(CB)) u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_prod),
		.vld_s3   (vld_s3),
		.ad_s2    (ad_s2),
		.bd_s2    (bd_s2),
		.c_s2     (c_s2),
		.ac_s2    (ac_s2),
		.ea_s2    (ea_s2),
		.eb_s2    (eb_s2),
		.absad_s3 (absad_s3),
		.absbd_s3 (absbd_s3),
		.ea_s3    (ea_s3),
		.eb_s3    (eb_s3),
		.pa_s3    (pa_s3),
		.pb_s3    (pb_s3),
		.ml0_s3   (ml0_s3),
		.ml1_s3   (ml1_s3),
		.mh0_s3   (mh0_s3),
		.mh1_s3   (mh1_s3)
	);

	obb_cmp #(.COORD_BITS(CB), .AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_cmp),
		.vld_s5     (vld_s5),
		.overlap_s5 (overlap),
		.absad_s3   (absad_s3),
		.absbd_s3   (absbd_s3),
		.ea_s3      (ea_s3),
		.eb_s3      (eb_s3),
		.pa_s3      (pa_s3),
		.pb_s3      (pb_s3),
		.ml0_s3     (ml0_s3),
		.ml1_s3     (ml1_s3),
		.mh0_s3     (mh0_s3),
		.mh1_s3     (mh1_s3)
	);

	assign out_valid = vld_s5;

	// pipe only holds off input while a finished result is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a blocked result");

	// a blocked result keeps its flag
	a_hold_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(overlap))
		else $error("result flag changed while blocked");

	// an input transfer followed by an advance into each later stage reaches the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		($past(in_valid && in_ready, 5) && $past(in_ready, 4) && $past(in_ready, 3)
			&& $past(in_ready, 2) && $past(in_ready, 1)) |-> out_valid)
		else $error("transfer lost in pipe");

endmodule

[tb/obb_obb_overlap_test_test.sv]
// ----------------------------------------------------------------------------
// obb_obb_overlap_test_test
// streams oriented box pairs through the overlap pipe and checks every flag
// against a local separating axis predictor, with random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module obb_obb_overlap_test_test;

	localparam int CB = 16;
	localparam int FB = 14;
	localparam int WATCH_LIMIT = 20000;

	typedef logic signed [CB-1:0] comp_t;
	typedef struct {
		logic [47:0] f [10];
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [47:0] fld [10];
	logic out_valid;
	logic out_ready = 1'b0;
	logic overlap;

	bit expected_flags [$];
	int errors = 0;
	int sent = 0;
	int got = 0;
	int n_overlap = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit hold_off = 1'b0;

	initial begin
		for (int i = 0; i < 10; i++) fld[i] = '0;
	end

	always #5 clk = ~clk;

	obb_obb_overlap_test #(.COORD_BITS(CB), .AXIS_FRAC_BITS(FB)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.box_a_center(fld[0]), .box_a_axis_u(fld[1]), .box_a_axis_v(fld[2]),
		.box_a_axis_w(fld[3]), .box_a_half_sizes(fld[4]), .box_b_center(fld[5]),
		.box_b_axis_u(fld[6]), .box_b_axis_v(fld[7]), .box_b_axis_w(fld[8]),
		.box_b_half_sizes(fld[9]), .out_valid(out_valid), .out_ready(out_ready),
		.overlap(overlap)
	);

	function automatic longint comp(logic [47:0] w, int k, bit sgn);
		logic [CB-1:0] v;
		v = w[k*CB +: CB];
		return sgn ? longint'(comp_t'(v)) : longint'(v);
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	// separating axis test at exact width
	function automatic bit boxes_overlap(pair_t p);
		longint ea [3], eb [3], d [3], au [3][3], bu [3][3];
		longint c [3][3], ac [3][3], ad [3], bd [3];
		logic signed [127:0] lhs, rhs, r, r0, r1;
		int i1, i2, j1, j2;
		bit sep;
		sep = 1'b0;
		for (int k = 0; k < 3; k++) begin
			ea[k] = comp(p.f[4], k, 0);
			eb[k] = comp(p.f[9], k, 0);
			d[k] = comp(p.f[5], k, 1) - comp(p.f[0], k, 1);
			for (int i = 0; i < 3; i++) begin
				au[i][k] = comp(p.f[1+i], k, 1);
				bu[i][k] = comp(p.f[6+i], k, 1);
			end
		end
		for (int i = 0; i < 3; i++) begin
			ad[i] = 0;
			bd[i] = 0;
			for (int k = 0; k < 3; k++) begin
				ad[i] += au[i][k] * d[k];
				bd[i] += bu[i][k] * d[k];
			end
			for (int j = 0; j < 3; j++) begin
				c[i][j] = 0;
				for (int k = 0; k < 3; k++) c[i][j] += au[i][k] * bu[j][k];
				ac[i][j] = mag(c[i][j]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			lhs = 128'(mag(ad[i])) <<< FB;
			rhs = 128'(ea[i]) <<< (2*FB);
			for (int j = 0; j < 3; j++) rhs += 128'(eb[j]) * 128'(ac[i][j]);
			if (lhs > rhs) sep = 1'b1;
			lhs = 128'(mag(bd[i])) <<< FB;
			rhs = 128'(eb[i]) <<< (2*FB);
			for (int j = 0; j < 3; j++) rhs += 128'(ea[j]) * 128'(ac[j][i]);
			if (lhs > rhs) sep = 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			i1 = (i + 1) % 3;
			i2 = (i + 2) % 3;
			for (int j = 0; j < 3; j++) begin
				j1 = (j + 1) % 3;
				j2 = (j + 2) % 3;
				r = 128'(ad[i2]) * 128'(c[i1][j]) - 128'(ad[i1]) * 128'(c[i2][j]);
				if (r < 0) r = -r;
				r0 = 128'(ea[i1]) * 128'(ac[i2][j]) + 128'(ea[i2]) * 128'(ac[i1][j]);
				r1 = 128'(eb[j1]) * 128'(ac[i][j2]) + 128'(eb[j2]) * 128'(ac[i][j1]);
				if (r > ((r0 + r1) <<< FB)) sep = 1'b1;
			end
		end
		return !sep;
	endfunction

	task automatic report(string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	task automatic send_pair(pair_t p);
		while (!quiet && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		for (int i = 0; i < 10; i++) fld[i] <= p.f[i];
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_flags.push_back(boxes_overlap(p));
		sent++;
		@(negedge clk);
	endtask

	task automatic stop_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [47:0] pack3(int x, int y, int z);
		return {CB'(z), CB'(y), CB'(x)};
	endfunction

	function automatic logic [47:0] unit_axis(int k, bit neg);
		int one;
		one = neg ? -(1 << FB) : (1 << FB);
		return pack3(k == 0 ? one : 0, k == 1 ? one : 0, k == 2 ? one : 0);
	endfunction

	function automatic logic [47:0] rnd48();
		return {16'($urandom_range(16'hffff)), $urandom()};
	endfunction

	// plausible pair: near-unit axes (fully random axes one time in four), modest extents, centers close together
	function automatic pair_t plausible_pair();
		pair_t p;
		int s;
		s = $urandom_range(3);
		for (int b = 0; b < 2; b++) begin
			p.f[5*b] = pack3($signed($urandom_range(2048)) - 1024,
				$signed($urandom_range(2048)) - 1024, $signed($urandom_range(2048)) - 1024);
			for (int a = 0; a < 3; a++) begin
				if (s == 0)
					p.f[5*b+1+a] = rnd48();
				else begin
					p.f[5*b+1+a] = unit_axis(a, $urandom_range(1));
					p.f[5*b+1+a][(((a+1)%3)*CB) +: CB] = CB'($signed($urandom_range(8000)) - 4000);
				end
			end
			p.f[5*b+4] = pack3($urandom_range(1024), $urandom_range(1024), $urandom_range(1024));
		end
		return p;
	endfunction

	task automatic test_directed();
		pair_t p;
		for (int b = 0; b < 2; b++) begin
			for (int a = 0; a < 3; a++) p.f[5*b+1+a] = unit_axis(a, 0);
			p.f[5*b] = '0;
			p.f[5*b+4] = pack3(256, 256, 256);
		end
		send_pair(p);
		// touching faces, distance equal to radii sum, then just beyond
		p.f[5] = pack3(512, 0, 0);
		send_pair(p);
		p.f[5] = pack3(513, 0, 0);
		send_pair(p);
		// zero axes on box A: only the face axes of B can still separate
		for (int a = 1; a < 4; a++) p.f[a] = '0;
		send_pair(p);
		for (int v = 0; v < 4; v++) begin
			for (int i = 0; i < 10; i++) p.f[i] = (v == 0) ? '0 : (v == 1) ? '1 :
				(v == 2) ? {3{16'h8000}} : {3{16'h7fff}};
			send_pair(p);
		end
		// mixed extremes on each field
		for (int i = 0; i < 10; i++) begin
			p = plausible_pair();
			p.f[i] = (i % 2) ? {3{16'h8000}} : '1;
			send_pair(p);
		end
		// rotated B about z
		p = plausible_pair();
		p.f[6] = pack3(11585, 11585, 0);
		p.f[7] = pack3(-11585, 11585, 0);
		p.f[8] = unit_axis(2, 0);
		send_pair(p);
	endtask

	task automatic test_random(int count);
		pair_t p;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) < 8)
				p = plausible_pair();
			else
				for (int i = 0; i < 10; i++) p.f[i] = rnd48();
			send_pair(p);
		end
	endtask

	task automatic test_back_pressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			test_random(30);
		join
	endtask

	task automatic test_drain_pause();
		test_random(20);
		stop_input();
		wait (expected_flags.size() == 0);
		@(negedge clk);
		test_random(20);
	endtask

	task automatic test_no_idle();
		quiet = 1'b1;
		test_random(100);
		quiet = 1'b0;
	endtask

	always @(negedge clk)
		out_ready <= !hold_off && (quiet || $urandom_range(99) >= 31);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got++;
			if (expected_flags.size() == 0)
				report("result with no pending expectation");
			else begin
				if (overlap !== expected_flags[0])
					report($sformatf("result %0d overlap %b, predicted %b", got, overlap,
						expected_flags[0]));
				n_overlap += expected_flags[0];
				void'(expected_flags.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("watchdog expired, %0d results pending", expected_flags.size());
			$display("obb_obb_overlap_test_test NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(150);
		test_back_pressure();
		test_drain_pause();
		test_no_idle();
		test_random(200);
		stop_input();
		wait (expected_flags.size() == 0);
		repeat (10) @(posedge clk);
		if (expected_flags.size() != 0) report("expectations left over");
		$display("%0d box pairs sent, %0d results checked, %0d overlapping", sent, got,
			n_overlap);
		if (errors == 0)
			$display("obb_obb_overlap_test_test OK");
		else
			$display("obb_obb_overlap_test_test NOT OK");
		$finish;
	end

endmodule
